### hdl/cfcq_pkg.sv
// ----------------------------------------------------------------------------
// cfcq_pkg - shared types and constants
// Word layouts, status codes and ring sizing for the command frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cfcq_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [7:0]  CMD_POSITION = 8'h10;
    localparam logic [7:0]  CMD_ESTOP    = 8'h13;

    localparam logic FUNC_DELIVER = 1'b0;
    localparam logic FUNC_FETCH   = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_BADSUM   = 3'd0,
        ST_POSITION = 3'd1,
        ST_ESTOP    = 3'd2,
        ST_STORED   = 3'd3,
        ST_FULL     = 3'd4,
        ST_FETCHED  = 3'd5,
        ST_EMPTY    = 3'd6
    } status_t;

    typedef struct packed {
        logic        func;
        logic [7:0]  cmd_code;
        logic [39:0] payload_bytes;
        logic [7:0]  frame_sum;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        emergency_stop;
        logic [7:0]  fetched_cmd;
        logic [39:0] fetched_payload;
    } result_t;

    // Dispatch decision for one word
    typedef struct packed {
        status_t status;
        logic    push;
        logic    pop;
        logic    load_pos;
        logic    set_stop;
    } action_t;

    // Ring state seen by the dispatcher and result path
    typedef struct packed {
        logic        full;
        logic        empty;
        logic [7:0]  head_cmd;
        logic [39:0] head_payload;
    } ring_stat_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] n;
        if (s == SLOT_LAST)
        begin
            n = '0;
        end
        else
        begin
            n = s + SLOT_W'(1);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### hdl/cfcq_dispatch.sv
// ----------------------------------------------------------------------------
// cfcq_dispatch - frame check and command dispatch
// Verify the byte sum and pick the action for one registered word.
// ----------------------------------------------------------------------------
`default_nettype none

module cfcq_dispatch
    import cfcq_pkg::*;
(
    input  wire logic       valid,
    input  wire item_t      item,
    input  wire ring_stat_t ring,
    output action_t         action
);

    logic [7:0] sum;
    logic       sum_ok;

    assign sum = item.cmd_code
               + item.payload_bytes[39:32]
               + item.payload_bytes[31:24]
               + item.payload_bytes[23:16]
               + item.payload_bytes[15:8]
               + item.payload_bytes[7:0];
    assign sum_ok = (sum == item.frame_sum);

    always_comb
    begin
        action = '{status: ST_BADSUM, push: 1'b0, pop: 1'b0,
                   load_pos: 1'b0, set_stop: 1'b0};
        if (item.func == FUNC_FETCH)
        begin
            if (ring.empty)
            begin
                action.status = ST_EMPTY;
            end
            else
            begin
                action.status = ST_FETCHED;
                action.pop    = valid;
            end
        end
        else if (!sum_ok)
        begin
            action.status = ST_BADSUM;
        end
        else if (item.cmd_code == CMD_POSITION)
        begin
            action.status   = ST_POSITION;
            action.load_pos = valid;
        end
        else if (item.cmd_code == CMD_ESTOP)
        begin
            action.status   = ST_ESTOP;
            action.set_stop = valid;
        end
        else if (ring.full)
        begin
            action.status = ST_FULL;
        end
        else
        begin
            action.status = ST_STORED;
            action.push   = valid;
        end
    end

endmodule

`default_nettype wire

### hdl/cfcq_slot_ring.sv
// ----------------------------------------------------------------------------
// cfcq_slot_ring - command slot ring
// Slot store with occupancy map and write/read slot indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module cfcq_slot_ring
    import cfcq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        pop,
    input  wire logic [7:0]  wr_cmd,
    input  wire logic [39:0] wr_payload,
    output ring_stat_t       stat
);

    logic [47:0]           slot_store_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] occ_reg, occ_next;
    logic [SLOT_W-1:0]     wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0]     rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0]     wr_adv, rd_adv;

    assign wr_adv = next_slot(wr_slot_reg);
    assign rd_adv = next_slot(rd_slot_reg);

    assign stat.full         = &occ_reg;
    assign stat.empty        = ~|occ_reg;
    assign stat.head_cmd     = slot_store_reg[rd_adv][47:40];
    assign stat.head_payload = slot_store_reg[rd_adv][39:0];

    always_comb
    begin
        occ_next     = occ_reg;
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        if (push)
        begin
            wr_slot_next         = wr_adv;
            occ_next[wr_adv]     = 1'b1;
        end
        if (pop)
        begin
            rd_slot_next         = rd_adv;
            occ_next[rd_adv]     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            wr_slot_reg <= SLOT_LAST;
            rd_slot_reg <= SLOT_LAST;
        end
        else
        begin
            occ_reg     <= occ_next;
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
        end
    end

    // Store the entry; unwritten slots are never read
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_store_reg[wr_adv] <= {wr_cmd, wr_payload};
        end
    end

endmodule

`default_nettype wire

### hdl/command_frame_checker_queue_top.sv
// ----------------------------------------------------------------------------
// command_frame_checker_queue_top - command frame checker and queue
// Check frame sums, dispatch position and stop commands, queue the rest.
// ----------------------------------------------------------------------------
// A word is taken at every clock edge where start is high; busy stays low, so
// a new word may follow in every cycle. Each word yields exactly one result,
// shown on result for one cycle with done high. A taken word is loaded into
// the input register, and its result into the result register, which drives
// result and done directly. The receiver cannot stall:
// sample result whenever done is high, or it is lost. Words are processed in
// order and each one sees all state left by the word before it, so a fetch
// right after a store into an empty ring returns it. func 0 delivers a frame:
// a bad byte sum drops it, command 0x10 loads X and Y, command 0x13 latches
// the emergency stop until reset, anything else goes into a 16-slot ring or
// is refused as full. func 1 pops the oldest ring entry or reports empty.
// fetched_cmd and fetched_payload are zero unless the status is fetched.
// No clearing pass after reset: the ring is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_checker_queue_top
    import cfcq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire item_t item,
    output logic       done,
    output result_t    result
);

    // Input register
    logic       in_valid_reg;
    item_t      in_item_reg;

    // Architectural state
    logic [15:0] pos_x_reg, pos_x_next;
    logic [15:0] pos_y_reg, pos_y_next;
    logic        stop_reg, stop_next;

    // Result register
    logic        done_reg;
    result_t     result_reg, result_next;

    action_t     action;
    ring_stat_t  ring;

    // Every stage advances every cycle, never hold off the sender
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            in_item_reg <= item;
        end
    end

    cfcq_dispatch u_dispatch (
        .valid  (in_valid_reg),
        .item   (in_item_reg),
        .ring   (ring),
        .action (action)
    );

    cfcq_slot_ring u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (action.push),
        .pop        (action.pop),
        .wr_cmd     (in_item_reg.cmd_code),
        .wr_payload (in_item_reg.payload_bytes),
        .stat       (ring)
    );

    // Update positions and stop flag, build the result word
    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        stop_next  = stop_reg | action.set_stop;
        if (action.load_pos)
        begin
            pos_x_next = in_item_reg.payload_bytes[39:24];
            pos_y_next = in_item_reg.payload_bytes[23:8];
        end
        result_next.status          = action.status;
        result_next.pos_x           = pos_x_next;
        result_next.pos_y           = pos_y_next;
        result_next.emergency_stop  = stop_next;
        result_next.fetched_cmd     = '0;
        result_next.fetched_payload = '0;
        if (action.status == ST_FETCHED)
        begin
            result_next.fetched_cmd     = ring.head_cmd;
            result_next.fetched_payload = ring.head_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            stop_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            stop_reg  <= stop_next;
            done_reg  <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### test/cfcq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfcq_result_checker - result predictor and scoreboard for the frame queue
// Watch accepted words, predict the status word of each one from a private
// model of the sum check, position and stop registers and the slot ring, and
// compare every result word against the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module cfcq_result_checker
    import cfcq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  logic    done,
    input  result_t result,
    output int      mismatch_count,
    output int      pending_results
);

    logic [47:0]           slot_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] occupied;
    logic [SLOT_W-1:0]     wr_idx;
    logic [SLOT_W-1:0]     rd_idx;
    logic [15:0]           x_reg;
    logic [15:0]           y_reg;
    logic                  stop_reg;
    result_t               expected_results [$];

    function automatic logic [SLOT_W-1:0] ring_advance(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W-1:0] n;
        if (idx == SLOT_W'(SLOT_COUNT - 1))
        begin
            n = '0;
        end
        else
        begin
            n = idx + SLOT_W'(1);
        end
        return n;
    endfunction

    // Apply one word to the model and build the result it should produce.
    task automatic predict_frame_result(input item_t w, output result_t r);
        logic [7:0] sum;
        sum = w.cmd_code;
        for (int i = 0; i < 5; i++)
        begin
            sum = sum + w.payload_bytes[8*i +: 8];
        end
        r = '0;
        if (w.func == FUNC_DELIVER)
        begin
            if (sum != w.frame_sum)
            begin
                r.status = ST_BADSUM;
            end
            else if (w.cmd_code == CMD_POSITION)
            begin
                x_reg    = w.payload_bytes[39:24];
                y_reg    = w.payload_bytes[23:8];
                r.status = ST_POSITION;
            end
            else if (w.cmd_code == CMD_ESTOP)
            begin
                stop_reg = 1'b1;
                r.status = ST_ESTOP;
            end
            else if (&occupied)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                wr_idx           = ring_advance(wr_idx);
                occupied[wr_idx] = 1'b1;
                slot_mem[wr_idx] = {w.cmd_code, w.payload_bytes};
                r.status         = ST_STORED;
            end
        end
        else
        begin
            if (occupied == '0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                rd_idx                             = ring_advance(rd_idx);
                occupied[rd_idx]                   = 1'b0;
                {r.fetched_cmd, r.fetched_payload} = slot_mem[rd_idx];
                r.status                           = ST_FETCHED;
            end
        end
        r.pos_x          = x_reg;
        r.pos_y          = y_reg;
        r.emergency_stop = stop_reg;
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t pred;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_mem[i] = '0;
            end
            occupied = '0;
            wr_idx   = SLOT_W'(SLOT_COUNT - 1);
            rd_idx   = SLOT_W'(SLOT_COUNT - 1);
            x_reg    = '0;
            y_reg    = '0;
            stop_reg = 1'b0;
            expected_results.delete();
            mismatch_count  = 0;
            pending_results = 0;
        end
        else
        begin
            // Check the result word first; it belongs to an older word.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation, status %0d", result.status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.status), 64'(result.status));
                    check_field("pos_x", 64'(want.pos_x), 64'(result.pos_x));
                    check_field("pos_y", 64'(want.pos_y), 64'(result.pos_y));
                    check_field("emergency_stop", 64'(want.emergency_stop),
                                64'(result.emergency_stop));
                    check_field("fetched_cmd", 64'(want.fetched_cmd),
                                64'(result.fetched_cmd));
                    check_field("fetched_payload", 64'(want.fetched_payload),
                                64'(result.fetched_payload));
                end
            end
            if (start && !busy)
            begin
                predict_frame_result(item, pred);
                expected_results.push_back(pred);
            end
            pending_results = expected_results.size();
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench top for the command frame checker and queue
// Drive directed and random command words into the block, with random gaps,
// and leave all prediction and comparison to the result checker beside it.
// ----------------------------------------------------------------------------

module tb;
    import cfcq_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;
    int      mismatch_count;
    int      pending_results;

    command_frame_checker_queue_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // The checker sees the same pins as the block and reports back only a
    // failure count and how many result words are still outstanding.
    cfcq_result_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .item            (item),
        .done            (done),
        .result          (result),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Build a deliver word; a bad sum is the good sum plus a nonzero offset,
    // so every wrong value can show up.
    function automatic item_t build_frame(input logic [7:0] cmd,
                                          input logic [39:0] payload,
                                          input bit good_sum);
        item_t      w;
        logic [7:0] sum;
        sum = cmd;
        for (int i = 0; i < 5; i++)
        begin
            sum = sum + payload[8*i +: 8];
        end
        w.func          = FUNC_DELIVER;
        w.cmd_code      = cmd;
        w.payload_bytes = payload;
        w.frame_sum     = good_sum ? sum : sum + 8'($urandom_range(255, 1));
        return w;
    endfunction

    // Fetch word with random junk in the fields the block must ignore.
    function automatic item_t build_fetch();
        item_t w;
        w      = item_t'({$urandom, $urandom});
        w.func = FUNC_FETCH;
        return w;
    endfunction

    // Enter at a rising edge; return at the edge that took the word, with
    // start still high so the next word can follow back to back.
    task automatic send_word(input item_t w, input bit may_idle);
        bit taken;
        if (may_idle)
        begin
            // Hold off again with a chance of 11 in a hundred each time.
            while ($urandom_range(99) < 11)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        item  <= w;
        taken = 1'b0;
        while (!taken)
        begin
            // Sample busy mid-cycle, where it is stable up to the next edge.
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int unsigned n_words;
        int unsigned burst_len;
        int unsigned fetch_pct;
        int unsigned roll;
        logic [7:0]  cmd;
        item_t       w;

        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty ring, bad sums on every command class, position
        // extremes, payload extremes through the ring, sticky stop.
        send_word(build_fetch(), 1'b0);
        send_word(build_frame(8'h42, 40'({$urandom, $urandom}), 1'b0), 1'b0);
        send_word(build_frame(CMD_POSITION, '1, 1'b0), 1'b0);
        send_word(build_frame(CMD_ESTOP, '0, 1'b0), 1'b0);
        send_word(build_frame(CMD_POSITION, '1, 1'b1), 1'b0);
        send_word(build_frame(CMD_POSITION, '0, 1'b1), 1'b0);
        send_word(build_frame(8'h00, '0, 1'b1), 1'b0);
        send_word(build_frame(8'hFF, '1, 1'b1), 1'b0);
        send_word(build_frame(8'h11, 40'h01_2345_6789, 1'b1), 1'b0);
        send_word(build_fetch(), 1'b0);
        send_word(build_fetch(), 1'b0);
        send_word(build_fetch(), 1'b0);
        send_word(build_fetch(), 1'b0);
        send_word(build_frame(CMD_ESTOP, 40'({$urandom, $urandom}), 1'b1), 1'b0);
        send_word(build_frame(CMD_ESTOP, '1, 1'b1), 1'b0);
        send_word(build_frame(8'h12, 40'({$urandom, $urandom}), 1'b1), 1'b0);
        send_word(build_frame(8'h0F, 40'({$urandom, $urandom}), 1'b1), 1'b0);
        send_word(build_fetch(), 1'b1);

        // Random: bursts that lean toward filling the ring, draining it, or
        // neither, so full, empty and the ring wrap all come up often.
        n_words = 0;
        while (n_words < 1550)
        begin
            roll      = $urandom_range(2);
            burst_len = $urandom_range(40, 4);
            fetch_pct = (roll == 0) ? 12 : ((roll == 1) ? 85 : 50);
            repeat (burst_len)
            begin
                if ($urandom_range(99) < fetch_pct)
                begin
                    w = build_fetch();
                end
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 8)
                    begin
                        cmd = CMD_POSITION;
                    end
                    else if (roll < 11)
                    begin
                        cmd = CMD_ESTOP;
                    end
                    else
                    begin
                        cmd = 8'($urandom);
                    end
                    w = build_frame(cmd, 40'({$urandom, $urandom}),
                                    $urandom_range(99) < 88);
                end
                // Run a long stretch with no gaps at all.
                send_word(w, !(n_words >= 600 && n_words < 900));
                n_words++;
            end
        end
        start <= 1'b0;

        // Drain: wait for every result word, then idle on to catch strays.
        do
        begin
            @(negedge clk);
        end
        while (pending_results != 0);
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
